// ===== hdl/coapf_pkg.sv =====
// coapf_pkg: types and constants shared by the CoAP option finder.
// No dependencies.
package coapf_pkg;

  localparam int unsigned PosW = 16;
  localparam logic [PosW-1:0] PosMax = '1;
  localparam logic [15:0] WantedReset = 16'd11;
  localparam logic [3:0] NibbleMaxShort = 4'd12;
  localparam logic [3:0] NibbleExt8 = 4'd13;
  localparam logic [3:0] NibbleExt16 = 4'd14;
  localparam logic [3:0] NibbleBad = 4'd15;
  localparam logic [15:0] Ext8Bias = 16'd13;
  localparam logic [15:0] Ext16Bias = 16'd269;
  localparam logic [PosW-1:0] HeaderLast = 16'd3;
  localparam logic [7:0] PayloadMarker = 8'hFF;

  typedef enum logic [3:0] {
    PH_HEADER, PH_TOKEN, PH_OPT, PH_DELTA8, PH_DELTA16H, PH_DELTA16L,
    PH_LEN8, PH_LEN16H, PH_LEN16L, PH_VALUE, PH_PAYLOAD, PH_BAD
  } phase_t;

  typedef enum logic [1:0] {
    ST_FOUND, ST_NOT_FOUND, ST_MALFORMED, ST_SHORT
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } item_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] value_off;
    logic [15:0] value_len;
    logic [15:0] body_off;
  } result_t;

endpackage

// ===== hdl/coapf_in_reg.sv =====
// coapf_in_reg: input register of the option finder, one byte request held.
// Depends on coapf_pkg.
module coapf_in_reg
  import coapf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic       in_tlast,
  input  logic       step,
  output logic       item_valid,
  output item_t      item
);

  logic  valid_r, valid_nxt;
  item_t item_r, item_nxt;

  assign in_tready = !valid_r || step;

  always_comb begin
    valid_nxt = valid_r;
    item_nxt  = item_r;
    if (in_tvalid && in_tready) begin
      valid_nxt = 1'b1;
      item_nxt  = '{data_byte: in_tdata, last: in_tlast};
    end else if (step) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    item_r <= item_nxt;
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

// ===== hdl/coapf_parser.sv =====
// coapf_parser: per-byte CoAP header/option decode and match tracking.
// Depends on coapf_pkg.
module coapf_parser
  import coapf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  item_t       item,
  input  logic [15:0] wanted,
  output result_t     result
);

  phase_t        phase_r, phase_nxt;
  logic [15:0]   pos_r, pos_nxt;
  logic [3:0]    tok_r, tok_nxt;
  logic [15:0]   prev_r, prev_nxt;
  logic [15:0]   delta_r, delta_nxt;
  logic [15:0]   len_r, len_nxt;
  logic [3:0]    pend_r, pend_nxt;
  logic [7:0]    ext_r, ext_nxt;
  logic [15:0]   vrem_r, vrem_nxt;
  logic [15:0]   moff_r, moff_nxt;
  logic [15:0]   mlen_r, mlen_nxt;
  logic [15:0]   pstart_r, pstart_nxt;
  logic          long_r, long_nxt;

  logic [7:0]    b;
  logic [3:0]    dn, ln, ln_cur;
  logic          do_begin, do_end;
  logic [15:0]   dsel, lsel, num, idx_inc;

  assign b       = item.data_byte;
  assign dn      = b[7:4];
  assign ln      = b[3:0];
  assign idx_inc = pos_r + 16'd1;

  always_comb begin
    phase_nxt  = phase_r;
    pos_nxt    = pos_r;
    tok_nxt    = tok_r;
    prev_nxt   = prev_r;
    delta_nxt  = delta_r;
    len_nxt    = len_r;
    pend_nxt   = pend_r;
    ext_nxt    = ext_r;
    vrem_nxt   = vrem_r;
    moff_nxt   = moff_r;
    mlen_nxt   = mlen_r;
    pstart_nxt = pstart_r;
    long_nxt   = long_r;
    do_begin   = 1'b0;
    do_end     = 1'b0;
    dsel       = 16'd0;
    lsel       = 16'd0;
    num        = 16'd0;
    ln_cur     = (phase_r == PH_OPT) ? ln : pend_r;
    result     = '{status: ST_NOT_FOUND, value_off: 16'd0,
                   value_len: 16'd0, body_off: 16'd0};

    if (pos_r == PosMax) begin
      long_nxt  = 1'b1;
      phase_nxt = PH_BAD;
    end else begin
      case (phase_r)
        PH_HEADER: begin
          if (pos_r == 16'd0) tok_nxt = ln;
          if (pos_r >= HeaderLast) phase_nxt = (tok_r != 4'd0) ? PH_TOKEN : PH_OPT;
        end
        PH_TOKEN: begin
          tok_nxt = tok_r - 4'd1;
          if (tok_nxt == 4'd0) phase_nxt = PH_OPT;
        end
        PH_OPT: begin
          if (b == PayloadMarker) begin
            pstart_nxt = idx_inc;
            phase_nxt  = PH_PAYLOAD;
          end else if (dn == NibbleBad || ln == NibbleBad) begin
            phase_nxt = PH_BAD;
          end else begin
            pend_nxt = ln;
            if (dn == NibbleExt8) begin
              phase_nxt = PH_DELTA8;
            end else if (dn == NibbleExt16) begin
              phase_nxt = PH_DELTA16H;
            end else begin
              do_begin = 1'b1;
              dsel     = {12'd0, dn};
            end
          end
        end
        PH_DELTA8: begin
          do_begin = 1'b1;
          dsel     = {8'd0, b} + Ext8Bias;
        end
        PH_DELTA16H: begin
          ext_nxt   = b;
          phase_nxt = PH_DELTA16L;
        end
        PH_DELTA16L: begin
          do_begin = 1'b1;
          dsel     = {ext_r, b} + Ext16Bias;
        end
        PH_LEN8: begin
          do_end = 1'b1;
          lsel   = {8'd0, b} + Ext8Bias;
        end
        PH_LEN16H: begin
          ext_nxt   = b;
          phase_nxt = PH_LEN16L;
        end
        PH_LEN16L: begin
          do_end = 1'b1;
          lsel   = {ext_r, b} + Ext16Bias;
        end
        PH_VALUE: begin
          vrem_nxt = vrem_r - 16'd1;
          if (vrem_nxt == 16'd0) phase_nxt = PH_OPT;
        end
        default: begin
        end
      endcase

      if (do_begin) begin
        delta_nxt = dsel;
        if (ln_cur <= NibbleMaxShort) begin
          do_end = 1'b1;
          lsel   = {12'd0, ln_cur};
        end else if (ln_cur == NibbleExt8) begin
          phase_nxt = PH_LEN8;
        end else begin
          phase_nxt = PH_LEN16H;
        end
      end

      if (do_end) begin
        len_nxt  = lsel;
        num      = prev_r + (do_begin ? dsel : delta_r);
        prev_nxt = num;
        if (num == wanted) begin
          moff_nxt = idx_inc;
          mlen_nxt = lsel;
        end
        vrem_nxt  = lsel;
        phase_nxt = (lsel != 16'd0) ? PH_VALUE : PH_OPT;
      end
    end

    if (item.last) begin
      if (!long_nxt && pos_r < HeaderLast) begin
        result.status = ST_SHORT;
      end else if (long_nxt || phase_nxt == PH_BAD || phase_nxt == PH_HEADER ||
                   phase_nxt == PH_DELTA8 || phase_nxt == PH_DELTA16H ||
                   phase_nxt == PH_DELTA16L || phase_nxt == PH_LEN8 ||
                   phase_nxt == PH_LEN16H || phase_nxt == PH_LEN16L ||
                   phase_nxt == PH_VALUE) begin
        result.status = ST_MALFORMED;
      end else begin
        result.body_off = (phase_nxt == PH_PAYLOAD) ? pstart_nxt : idx_inc;
        if (mlen_nxt != 16'd0) begin
          result.status    = ST_FOUND;
          result.value_off = moff_nxt;
          result.value_len = mlen_nxt;
        end
      end
      phase_nxt  = PH_HEADER;
      pos_nxt    = 16'd0;
      tok_nxt    = 4'd0;
      prev_nxt   = 16'd0;
      delta_nxt  = 16'd0;
      len_nxt    = 16'd0;
      pend_nxt   = 4'd0;
      ext_nxt    = 8'd0;
      vrem_nxt   = 16'd0;
      moff_nxt   = 16'd0;
      mlen_nxt   = 16'd0;
      pstart_nxt = 16'd0;
      long_nxt   = 1'b0;
    end else if (pos_r != PosMax) begin
      pos_nxt = idx_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HEADER;
      pos_r    <= 16'd0;
      tok_r    <= 4'd0;
      prev_r   <= 16'd0;
      delta_r  <= 16'd0;
      len_r    <= 16'd0;
      pend_r   <= 4'd0;
      ext_r    <= 8'd0;
      vrem_r   <= 16'd0;
      moff_r   <= 16'd0;
      mlen_r   <= 16'd0;
      pstart_r <= 16'd0;
      long_r   <= 1'b0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      pos_r    <= pos_nxt;
      tok_r    <= tok_nxt;
      prev_r   <= prev_nxt;
      delta_r  <= delta_nxt;
      len_r    <= len_nxt;
      pend_r   <= pend_nxt;
      ext_r    <= ext_nxt;
      vrem_r   <= vrem_nxt;
      moff_r   <= moff_nxt;
      mlen_r   <= mlen_nxt;
      pstart_r <= pstart_nxt;
      long_r   <= long_nxt;
    end
  end

  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (step && item.last) |=> (pos_r == 16'd0 && phase_r == PH_HEADER))
    else $error("parser did not restart after final byte");

  a_long_pos: assert property (@(posedge clk) disable iff (!rst_n)
    long_r |-> (pos_r == PosMax))
    else $error("too-long flag set below maximum position");

endmodule

// ===== hdl/coap_option_finder.sv =====
// Final byte: input register first, then its result in the result register.
// Throughput: one byte per cycle; the input register holds a final byte
// only while the result register is full and not taken.
// Reset: rst_n synchronous, active low; parse state cleared, wanted option 11.
// Top level: input register, option parser, result register, config register.
// Depends on coapf_pkg, coapf_in_reg, coapf_parser.
module coap_option_finder
  import coapf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] data_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,   // [15:0] value_off, [31:16] value_len,
                                   // [47:32] body_off
  output logic [1:0]  out_tuser,   // [1:0] status
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  logic        item_valid, step, out_free, res_load;
  item_t       item;
  result_t     result;
  logic [15:0] wanted_r;
  logic        out_valid_r, out_valid_nxt;
  result_t     res_r, res_nxt;

  assign out_free = !out_valid_r || out_tready;
  assign step     = item_valid && (!item.last || out_free);
  assign res_load = step && item.last;

  coapf_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .step       (step),
    .item_valid (item_valid),
    .item       (item)
  );

  coapf_parser u_parser (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .item   (item),
    .wanted (wanted_r),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wanted_r <= WantedReset;
    end else if (cfg_wr_en) begin
      wanted_r <= cfg_wr_data;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    res_nxt       = res_r;
    if (res_load) begin
      out_valid_nxt = 1'b1;
      res_nxt       = result;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    res_r <= res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = res_r.status;
  assign out_tdata  = {res_r.body_off, res_r.value_len, res_r.value_off};

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |-> (!out_valid_r || out_tready))
    else $error("result register overwritten while held");

  a_hold_final: assert property (@(posedge clk) disable iff (!rst_n)
    (item_valid && item.last && out_valid_r && !out_tready) |-> !in_tready)
    else $error("input taken while final byte stalled");

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (res_r.status == ST_MALFORMED || res_r.status == ST_SHORT))
      |-> (out_tdata == 48'd0))
    else $error("malformed result carries non-zero fields");

  a_not_found: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.status == ST_NOT_FOUND)
      |-> (res_r.value_off == 16'd0 && res_r.value_len == 16'd0))
    else $error("not-found result carries a match");

endmodule
